### src/rmth_pkg.sv
package rmth_pkg;
  localparam int HalfCapacity = 512;
  localparam int AddrW = $clog2(HalfCapacity);
  localparam int SizeW = $clog2(HalfCapacity + 1);
  localparam int CountW = 11;
  localparam int DataW = 32;
  localparam int MedW = 33;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SizeW-1:0] size_t;

  typedef enum logic [1:0] {
    HeapOpPush = 2'd0,
    HeapOpReplace = 2'd1
  } heap_op_e;

  typedef struct packed {
    logic start;
    heap_op_e op;
    data_t value;
  } heap_cmd_t;

  // true when a sits above b in the given heap order
  function automatic logic goes_first(data_t a, data_t b, logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction
endpackage

### src/running_median_two_heaps_core.sv
// Running median over two 512-entry heaps, one RAM each.
// An item runs one up sift, or a down sift and then an up sift, each over up to 9 levels;
// a dropped item touches neither heap.
// Throughput: one item at a time; in_stall_o is high from acceptance until the result leaves,
// so the next item is accepted at the earliest in the cycle after the result is taken.
// Reset: async active low clears sizes and control; heap RAM contents are not cleared.
module running_median_two_heaps_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             sample_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [32:0]             median_doubled_o,
  output logic [10:0]                    element_count_o,
  output logic                           dropped_full_o
);
  import rmth_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StFirst = 5'b00010,
    StSecond = 5'b00100,
    StWait = 5'b01000,
    StOut = 5'b10000
  } st_e;

  st_e state_q, state_d;
  data_t v_q, mv_q;
  logic sec_lo_q, drop_q;
  heap_cmd_t lcmd, ucmd;
  logic lbusy, ubusy;
  data_t ltop, utop;
  size_t lsize, usize;
  logic acc;
  logic [SizeW:0] tot;
  logic [MedW-1:0] med_q;
  logic [CountW-1:0] cnt_q;
  logic odd;
  logic repl;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign median_doubled_o = med_q;
  assign element_count_o = cnt_q;
  assign dropped_full_o = drop_q;
  assign tot = {1'b0, lsize} + {1'b0, usize};
  assign odd = (lsize != usize);
  // a top is displaced and moved across when the item belongs on the other side
  assign repl = odd ? (v_q < ltop) : (usize != '0 && v_q > utop);

  rmth_heap u_lower (.clk_i, .rst_ni, .is_max_i(1'b1), .cmd_i(lcmd),
    .busy_o(lbusy), .top_o(ltop), .size_o(lsize));
  rmth_heap u_upper (.clk_i, .rst_ni, .is_max_i(1'b0), .cmd_i(ucmd),
    .busy_o(ubusy), .top_o(utop), .size_o(usize));

  always_comb begin
    state_d = state_q;
    lcmd = '{start: 1'b0, op: HeapOpPush, value: v_q};
    ucmd = '{start: 1'b0, op: HeapOpPush, value: v_q};
    case (state_q)
      StIdle: if (acc) state_d = StFirst;
      StFirst: begin
        if (drop_q) begin
          state_d = StWait;
        end else begin
          if (!odd) begin
            if (repl) begin
              ucmd = '{start: 1'b1, op: HeapOpReplace, value: v_q};
            end else begin
              lcmd = '{start: 1'b1, op: HeapOpPush, value: v_q};
            end
          end else if (!repl) begin
            ucmd = '{start: 1'b1, op: HeapOpPush, value: v_q};
          end else begin
            lcmd = '{start: 1'b1, op: HeapOpReplace, value: v_q};
          end
          state_d = repl ? StSecond : StWait;
        end
      end
      StSecond: begin
        if (!lbusy && !ubusy) begin
          if (sec_lo_q) begin
            lcmd = '{start: 1'b1, op: HeapOpPush, value: mv_q};
          end else begin
            ucmd = '{start: 1'b1, op: HeapOpPush, value: mv_q};
          end
          state_d = StWait;
        end
      end
      StWait: if (!lbusy && !ubusy) state_d = StOut;
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc) v_q <= sample_value_i;
    if (state_q == StFirst) begin
      // remember the displaced top to move across
      mv_q <= odd ? ltop : utop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sec_lo_q <= 1'b0;
      drop_q <= 1'b0;
      med_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (acc) drop_q <= (tot >= (SizeW+1)'(2*HalfCapacity));
      if (state_q == StFirst) begin
        // a second push follows only after a replace
        sec_lo_q <= !odd;
      end
      if (state_q == StWait && !lbusy && !ubusy) begin
        med_q <= odd ? {ltop, 1'b0} : ({ltop[DataW-1], ltop} + {utop[DataW-1], utop});
        cnt_q <= CountW'(tot);
      end
    end
  end

  // no item is accepted while a heap sifts; the result is taken only once both sifts have settled
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lbusy || ubusy) |-> in_stall_o) else $error("accept while sifting");
  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (lsize == usize || lsize == usize + 1'b1))
    else $error("heaps out of balance");
  a_drop_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && drop_q) |-> !lbusy && !ubusy) else $error("drop touched heaps");
endmodule

### src/rmth_heap.sv
module rmth_heap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                is_max_i,
  input  rmth_pkg::heap_cmd_t cmd_i,
  output logic                busy_o,
  output rmth_pkg::data_t     top_o,
  output rmth_pkg::size_t     size_o
);
  import rmth_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StUpRd = 6'b000010,
    StUpCmp = 6'b000100,
    StDnRd = 6'b001000,
    StDnCmp = 6'b010000,
    StDnCmp2 = 6'b100000
  } st_e;

  st_e state_q, state_d;
  data_t mem [HalfCapacity];
  data_t rd_q, left_q, top_q, val_q, val_d;
  size_t size_q, size_d, idx_q, idx_d, ch_q, ch_d;
  logic we;
  addr_t wa, ra;
  data_t wd;
  logic [SizeW:0] c1;

  assign busy_o = (state_q != StIdle);
  assign top_o = top_q;
  assign size_o = size_q;
  assign c1 = {idx_q, 1'b1};

  always_comb begin
    state_d = state_q;
    size_d = size_q;
    idx_d = idx_q;
    ch_d = ch_q;
    val_d = val_q;
    we = 1'b0;
    wa = idx_q[AddrW-1:0];
    wd = val_q;
    ra = '0;
    case (state_q)
      StIdle: begin
        if (cmd_i.start) begin
          val_d = cmd_i.value;
          if (cmd_i.op == HeapOpPush) begin
            idx_d = size_q;
            size_d = size_q + 1'b1;
            state_d = StUpRd;
          end else begin
            idx_d = '0;
            state_d = StDnRd;
          end
        end
      end
      StUpRd: begin
        if (idx_q == '0) begin
          we = 1'b1;
          state_d = StIdle;
        end else begin
          ch_d = (idx_q - 1'b1) >> 1;
          ra = ch_d[AddrW-1:0];
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        we = 1'b1;
        if (goes_first(val_q, rd_q, is_max_i)) begin
          wd = rd_q;
          idx_d = ch_q;
          state_d = StUpRd;
        end else begin
          state_d = StIdle;
        end
      end
      StDnRd: begin
        if (c1 >= {1'b0, size_q}) begin
          we = 1'b1;
          state_d = StIdle;
        end else begin
          ch_d = c1[SizeW-1:0];
          ra = c1[AddrW-1:0];
          state_d = StDnCmp;
        end
      end
      StDnCmp: begin
        // fetch the right child when it exists
        if ({1'b0, ch_q} + 1'b1 < {1'b0, size_q}) begin
          ra = ch_q[AddrW-1:0] + 1'b1;
          state_d = StDnCmp2;
        end else if (goes_first(rd_q, val_q, is_max_i)) begin
          we = 1'b1;
          wd = rd_q;
          idx_d = ch_q;
          state_d = StDnRd;
        end else begin
          we = 1'b1;
          state_d = StIdle;
        end
      end
      StDnCmp2: begin
        if (goes_first(rd_q, left_q, is_max_i)) begin
          if (goes_first(rd_q, val_q, is_max_i)) begin
            we = 1'b1;
            wd = rd_q;
            idx_d = ch_q + 1'b1;
            state_d = StDnRd;
          end else begin
            we = 1'b1;
            state_d = StIdle;
          end
        end else if (goes_first(left_q, val_q, is_max_i)) begin
          we = 1'b1;
          wd = left_q;
          idx_d = ch_q;
          state_d = StDnRd;
        end else begin
          we = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[ra];
    if (state_q == StDnCmp) left_q <= rd_q;
    if (we) mem[wa] <= wd;
    if (we && wa == '0) top_q <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      size_q <= '0;
      idx_q <= '0;
      ch_q <= '0;
      val_q <= '0;
    end else begin
      state_q <= state_d;
      size_q <= size_d;
      idx_q <= idx_d;
      ch_q <= ch_d;
      val_q <= val_d;
    end
  end

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= size_t'(HalfCapacity)) else $error("heap size overflow");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && cmd_i.start && cmd_i.op == HeapOpPush) |=>
    size_q == $past(size_q) + 1'b1) else $error("push did not grow heap");
  a_size_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |=> $stable(size_q)) else $error("size moved mid sift");
endmodule
